### sv/bsr_pkg.sv
// ----------------------------------------------------------------------------
// Bisection square root package
// Shared widths, status codes, sequencer states and compare flags.
// ----------------------------------------------------------------------------
package bsr_pkg;

    localparam int VALUE_W = 32;
    localparam int ROOT_W  = 31;
    localparam int TOL_W   = 31;
    localparam int STEPS_W = 6;
    localparam int SQ_W    = 2 * ROOT_W;

    localparam logic [TOL_W-1:0] TOL_RESET = 31'd66;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_NEG  = 2'd1,
        STAT_PREC = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_EVAL,
        ST_FIN
    } t_state;

    // Result of comparing mid squared against the target
    typedef struct packed {
        logic in_tol;
        logic below;
    } t_cmp;

endpackage

### sv/bsr_if.sv
// ----------------------------------------------------------------------------
// Bisection square root channels
// Valid/ready channels for input words, result words and tolerance writes.
// ----------------------------------------------------------------------------
interface bsr_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [bsr_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface bsr_out_if;
    logic                          valid;
    logic                          ready;
    logic [bsr_pkg::ROOT_W-1:0]    root;
    logic [1:0]                    status;
    logic [bsr_pkg::STEPS_W-1:0]   steps;

    modport source (output valid, output root, output status, output steps, input ready);
    modport sink   (input valid, input root, input status, input steps, output ready);
endinterface

interface bsr_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [bsr_pkg::TOL_W-1:0]   tolerance;

    modport source (output valid, output tolerance, input ready);
    modport sink   (input valid, input tolerance, output ready);
endinterface

### sv/bsr_sqcmp.sv
// ----------------------------------------------------------------------------
// Bisection square root square-and-compare unit
// Registers mid squared, then compares it against the target and tolerance.
// ----------------------------------------------------------------------------
module bsr_sqcmp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic [bsr_pkg::ROOT_W-1:0]        i_mid,
    input  logic [bsr_pkg::ROOT_W+FRAC_BITS-1:0] i_target,
    input  logic [bsr_pkg::TOL_W-1:0]         i_tol,
    output bsr_pkg::t_cmp                     o_cmp
);
    import bsr_pkg::*;

    localparam int TGT_W = ROOT_W + FRAC_BITS;
    localparam int CW    = (SQ_W > TGT_W) ? SQ_W : TGT_W;

    logic [SQ_W-1:0] r_sq;
    logic [CW-1:0]   sq_ext;
    logic [CW-1:0]   tgt_ext;
    logic [CW-1:0]   tol_ext;
    logic [CW-1:0]   diff_up;
    logic [CW-1:0]   diff_dn;
    logic [CW-1:0]   diff;

    // Square the midpoint, one product per cycle
    always_ff @(posedge i_clk) begin
        r_sq <= SQ_W'(i_mid) * SQ_W'(i_mid);
    end

    // Absolute error against target, checked against tolerance
    always_comb begin
        sq_ext       = CW'(r_sq);
        tgt_ext      = CW'(i_target);
        tol_ext      = CW'(i_tol) << FRAC_BITS;
        diff_up      = tgt_ext - sq_ext;
        diff_dn      = sq_ext - tgt_ext;
        o_cmp.below  = sq_ext < tgt_ext;
        diff         = o_cmp.below ? diff_up : diff_dn;
        o_cmp.in_tol = diff <= tol_ext;
    end

endmodule

### sv/bisection_square_root_unit.sv
// ----------------------------------------------------------------------------
// Bisection square root unit
// Square root of a signed fixed-point word by halving the search interval.
// ----------------------------------------------------------------------------
// One word is taken at a time. A negative input, zero or exactly one skips
// the search and goes straight to the result state. Any other value searches
// the interval [0, max(v, 1.0)]: each halving passes through the shared
// squaring multiplier and then through the wide error compare, and a search
// ends after at most 31 halvings. The result sits in an output register, and
// the next word is accepted as soon as the sequencer has handed its result
// over.
module bisection_square_root_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bsr_in_if.sink            i_in,
    bsr_out_if.source         o_out,
    bsr_cfg_if.sink           i_cfg
);
    import bsr_pkg::*;

    localparam int TGT_W = ROOT_W + FRAC_BITS;
    localparam logic [ROOT_W-1:0] ONE = ROOT_W'(1) << FRAC_BITS;

    t_state              r_state, n_state;
    logic [TOL_W-1:0]    r_tol;
    logic [ROOT_W-1:0]   r_lo, n_lo;
    logic [ROOT_W-1:0]   r_hi, n_hi;
    logic [ROOT_W-1:0]   r_mid, n_mid;
    logic [TGT_W-1:0]    r_target, n_target;
    logic [STEPS_W-1:0]  r_steps, n_steps;
    t_status             r_stat, n_stat;

    logic                r_out_valid;
    logic [ROOT_W-1:0]   r_out_root;
    t_status             r_out_stat;
    logic [STEPS_W-1:0]  r_out_steps;

    logic                in_take;
    logic                out_load;
    logic [ROOT_W-1:0]   in_v;
    logic [ROOT_W:0]     sum_up;
    logic [ROOT_W:0]     sum_dn;
    t_cmp                cmp;

    bsr_sqcmp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sqcmp (
        .i_clk    (i_clk),
        .i_mid    (r_mid),
        .i_target (r_target),
        .i_tol    (r_tol),
        .o_cmp    (cmp)
    );

    // Sequencer outputs
    always_comb begin
        i_in.ready  = (r_state == ST_IDLE);
        i_cfg.ready = 1'b1;
        in_take     = i_in.valid && (r_state == ST_IDLE);
        out_load    = (r_state == ST_FIN) && (!r_out_valid || o_out.ready);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    if (i_in.value[VALUE_W-1] || (in_v == '0) || (in_v == ONE)) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (cmp.in_tol || ((r_hi - r_lo) <= ROOT_W'(1))) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_FIN: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Interval and result update
    always_comb begin
        in_v     = i_in.value[ROOT_W-1:0];
        sum_up   = {1'b0, r_mid} + {1'b0, r_hi};
        sum_dn   = {1'b0, r_lo} + {1'b0, r_mid};
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_target = r_target;
        n_steps  = r_steps;
        n_stat   = r_stat;
        case (r_state)
            ST_IDLE: begin
                n_target = TGT_W'(in_v) << FRAC_BITS;
                n_lo     = '0;
                n_hi     = (in_v > ONE) ? in_v : ONE;
                n_mid    = n_hi >> 1;
                n_steps  = '0;
                n_stat   = STAT_OK;
                if (i_in.value[VALUE_W-1]) begin
                    n_mid  = '0;
                    n_stat = STAT_NEG;
                end else if ((in_v == '0) || (in_v == ONE)) begin
                    n_mid = in_v;
                end
            end
            ST_EVAL: begin
                if (cmp.in_tol) begin
                    n_stat = STAT_OK;
                end else if ((r_hi - r_lo) <= ROOT_W'(1)) begin
                    n_stat = STAT_PREC;
                end else if (cmp.below) begin
                    n_lo    = r_mid;
                    n_mid   = sum_up[ROOT_W:1];
                    n_steps = r_steps + STEPS_W'(1);
                end else begin
                    n_hi    = r_mid;
                    n_mid   = sum_dn[ROOT_W:1];
                    n_steps = r_steps + STEPS_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tol       <= TOL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_tol <= i_cfg.tolerance;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if ((r_state != ST_IDLE) || in_take) begin
            r_lo     <= n_lo;
            r_hi     <= n_hi;
            r_mid    <= n_mid;
            r_target <= n_target;
            r_steps  <= n_steps;
            r_stat   <= n_stat;
        end
        if (out_load) begin
            r_out_root  <= r_mid;
            r_out_stat  <= r_stat;
            r_out_steps <= r_steps;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.root   = r_out_root;
    assign o_out.status = r_out_stat;
    assign o_out.steps  = r_out_steps;

endmodule

### sv/bsr_check.sv
// ----------------------------------------------------------------------------
// Bisection square root port checker
// Watches the top-level ports for result and handshake consistency.
// ----------------------------------------------------------------------------
module bsr_check (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [bsr_pkg::ROOT_W-1:0]    i_root,
    input logic [1:0]                    i_status,
    input logic [bsr_pkg::STEPS_W-1:0]   i_steps
);
    import bsr_pkg::*;

    // Hold off new words right after one is taken
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after a word was taken");

    // A rejected negative word reports zero root and no halvings
    a_neg_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == STAT_NEG)) |-> ((i_root == '0) && (i_steps == '0)))
        else $error("negative input result is not clean");

    // Halvings are bounded by the interval width
    a_steps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_steps <= STEPS_W'(ROOT_W)))
        else $error("halving count out of range");

    // Stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_root) && $stable(i_status) && $stable(i_steps)))
        else $error("stalled result word changed");

endmodule

bind bisection_square_root_unit bsr_check u_bsr_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_root      (o_out.root),
    .i_status    (o_out.status),
    .i_steps     (o_out.steps)
);
